// File: hw/rtl/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared types and constants of the length-prefixed frame splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfs_pkg;

  // Header layout: 4 id bytes then 4 length bytes, both big-endian.
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned ID_BYTES    = 4;
  localparam int unsigned HDR_CNT_W   = $clog2(HDR_BYTES);

  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned MAX_LEN_W   = 31;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [MAX_LEN_W-1:0] max_len_t;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_MAX_BODY_LEN = 1'b0,
    REG_UNUSED       = 1'b1
  } reg_idx_t;

  localparam max_len_t MAX_LEN_RESET = max_len_t'(65535);
  localparam hdr_cnt_t HDR_LAST_IDX  = hdr_cnt_t'(HDR_BYTES - 1);
  localparam hdr_cnt_t HDR_ID_END    = hdr_cnt_t'(ID_BYTES);

endpackage

// File: hw/rtl/length_prefixed_frame_splitter.sv
// Timing: a result item is registered in the output register in the cycle after the
//   input item that causes it is accepted.
// Throughput: one input item per cycle unless in_stall; the header/body counter
//   update and the length compare sit between the state and output registers.
// Reset (rst_n, synchronous, active low): header collection, no pending result,
//   max_body_len back to 65535. No clearing pass.
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter
// Splits a byte stream of id/length-prefixed messages into tagged body bytes,
// with an empty mark for zero-length bodies and an error for over-long ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_splitter (
  input  logic             clk,
  input  logic             rst_n,

  // input byte channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,

  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_data_byte,
  output logic [31:0]      out_message_id,
  output logic             out_last,
  output logic             out_empty_body,
  output logic             out_too_long,

  // APB-style configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  lpfs_pkg::addr_t  paddr,
  input  lpfs_pkg::data_t  pwdata,
  output lpfs_pkg::data_t  prdata,
  output logic             pready
);

  import lpfs_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  max_len_t max_len_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr && (reg_idx == REG_MAX_BODY_LEN)) begin
      max_len_r <= pwdata[MAX_LEN_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_BODY_LEN: prdata = {{(DATA_W-MAX_LEN_W){1'b0}}, max_len_r};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Deframing state
  // --------------------------------------------------------------------------
  logic      in_body_r,   in_body_nxt;
  logic      skipping_r,  skipping_nxt;
  hdr_cnt_t  hdr_cnt_r,   hdr_cnt_nxt;
  len_t      id_r,        id_nxt;
  len_t      len_r,       len_nxt;
  len_t      left_r,      left_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  len_t        out_id_r;
  logic        out_last_r;
  logic        out_empty_r;
  logic        out_err_r;

  // result of the item being accepted
  logic        res_valid;
  logic [7:0]  res_data;
  logic        res_last;
  logic        res_empty;
  logic        res_err;

  logic        in_acc;
  logic        out_acc;
  len_t        left_dec;

  // The output register frees up in the same cycle it is taken, so the input
  // only stalls when a result is held back downstream.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign left_dec = left_r - len_t'(1);

  always_comb begin
    in_body_nxt  = in_body_r;
    skipping_nxt = skipping_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    id_nxt       = id_r;
    len_nxt      = len_r;
    left_nxt     = left_r;
    res_valid    = 1'b0;
    res_data     = '0;
    res_last     = 1'b0;
    res_empty    = 1'b0;
    res_err      = 1'b0;

    if (!in_body_r) begin
      if (hdr_cnt_r < HDR_ID_END) begin
        id_nxt  = {id_r[LEN_W-9:0], in_rx_byte};
      end else begin
        len_nxt = {len_r[LEN_W-9:0], in_rx_byte};
      end

      if (hdr_cnt_r != HDR_LAST_IDX) begin
        hdr_cnt_nxt = hdr_cnt_r + hdr_cnt_t'(1);
      end else begin
        // header complete: length is checked here
        hdr_cnt_nxt = '0;
        if (len_nxt == '0) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
          res_empty = 1'b1;
        end else begin
          in_body_nxt = 1'b1;
          left_nxt    = len_nxt;
          if (len_nxt > {1'b0, max_len_r}) begin
            skipping_nxt = 1'b1;
            res_valid    = 1'b1;
            res_last     = 1'b1;
            res_err      = 1'b1;
          end else begin
            skipping_nxt = 1'b0;
          end
        end
      end
    end else begin
      left_nxt = left_dec;
      if (left_dec == '0) begin
        in_body_nxt  = 1'b0;
        skipping_nxt = 1'b0;
        hdr_cnt_nxt  = '0;
      end
      if (!skipping_r) begin
        res_valid = 1'b1;
        res_data  = in_rx_byte;
        res_last  = (left_dec == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r  <= 1'b0;
      skipping_r <= 1'b0;
      hdr_cnt_r  <= '0;
      id_r       <= '0;
      len_r      <= '0;
      left_r     <= '0;
    end else if (in_acc) begin
      in_body_r  <= in_body_nxt;
      skipping_r <= skipping_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      left_r     <= left_nxt;
    end
  end

  // Output register: loaded on an accepted item with a result, else emptied
  // once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid || (out_valid_r && !out_acc);
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r  <= res_data;
      out_id_r    <= id_nxt;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
      out_err_r   <= res_err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = out_data_r;
  assign out_message_id = out_id_r;
  assign out_last       = out_last_r;
  assign out_empty_body = out_empty_r;
  assign out_too_long   = out_err_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skip_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    skipping_r |-> in_body_r)
    else $error("skipping outside a body");

  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (left_r != '0))
    else $error("in body with no bytes left");

  a_hdr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (hdr_cnt_r == '0))
    else $error("header count moved during a body");

  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_empty_r || out_err_r) |-> out_last_r && (out_data_r == '0))
    else $error("empty or error result without last or with data");

  a_mark_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_empty_r && out_err_r))
    else $error("empty and too long on one item");

endmodule
